// ===== hw/rtl/cnt_pkg.sv =====
// Shared types and constants of the CIGAR normalize and trim block.
package cnt_pkg;

  typedef enum logic [1:0] {
    ET_MATCH = 2'd0,
    ET_MISM  = 2'd1,
    ET_DEL   = 2'd2,
    ET_INS   = 2'd3
  } elem_type_e;

  typedef struct packed {
    elem_type_e  etype;
    logic        trim;
    logic [15:0] value;
  } elem_t;

  typedef struct packed {
    logic [15:0] min_ctx;
    logic        gap_del_first;
  } cfg_t;

  localparam logic REG_MIN_CTX   = 1'b0;
  localparam logic REG_GAP_ORDER = 1'b1;

  localparam logic [15:0] OUT_MAX = 16'hFFFF;

endpackage

// ===== hw/rtl/cnt_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module cnt_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/cnt_apb.sv =====
// APB configuration registers of the CIGAR normalize and trim block.
module cnt_apb (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cnt_pkg::cfg_t cfg_o
);
  import cnt_pkg::*;

  logic [15:0] min_q, min_d;
  logic        gdf_q, gdf_d;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    min_d = min_q;
    gdf_d = gdf_q;
    if (wr_en) begin
      case (paddr[2])
        REG_MIN_CTX:   min_d = pwdata[15:0];
        REG_GAP_ORDER: gdf_d = pwdata[0];
        default:       min_d = min_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MIN_CTX:   prdata = {16'd0, min_q};
      REG_GAP_ORDER: prdata = {31'd0, gdf_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 16'd0;
      gdf_q <= 1'b1;
    end else begin
      min_q <= min_d;
      gdf_q <= gdf_d;
    end
  end

  assign cfg_o.min_ctx       = min_q;
  assign cfg_o.gap_del_first = gdf_q;

endmodule

// ===== hw/rtl/cnt_ctrl.sv =====
// Element and result stores with the load, compaction, end-trim and output sequencer.
module cnt_ctrl #(
  parameter int MAX_ELEMENTS = 64,
  parameter int LENGTH_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cnt_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           element_type_i,
  input  logic                 element_trim_i,
  input  logic [15:0]          element_value_i,
  input  logic [39:0]          start_position_i,
  input  logic [39:0]          text_start_i,
  input  logic                 is_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cnt_pkg::elem_t       out_elem_o,
  output logic                 empty_o,
  output logic                 last_o,
  output logic                 overflow_o,
  output logic [39:0]          pos_o,
  output logic [39:0]          text_start_o
);
  import cnt_pkg::*;

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int LW = LENGTH_BITS;
  localparam int AW = (LW > 16) ? LW : 16;
  localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};
  localparam int EW = $bits(elem_t);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_FRD   = 3'd1;
  localparam logic [2:0] S_FPROC = 3'd2;
  localparam logic [2:0] S_BRD   = 3'd3;
  localparam logic [2:0] S_BPROC = 3'd4;
  localparam logic [2:0] S_EST   = 3'd5;
  localparam logic [2:0] S_ECAP  = 3'd6;
  localparam logic [2:0] S_EWAIT = 3'd7;

  function automatic logic [LW-1:0] clamp_len(logic [15:0] v);
    logic [AW-1:0] ve;
    ve = AW'(v);
    if (ve > AW'(LEN_MAX)) begin
      return LEN_MAX;
    end
    return LW'(ve);
  endfunction

  function automatic logic [LW-1:0] sat_add(logic [LW-1:0] a, logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LW] ? LEN_MAX : s[LW-1:0];
  endfunction

  function automatic logic [15:0] sat16(logic [LW-1:0] v);
    logic [AW-1:0] ve;
    ve = AW'(v);
    if (ve > AW'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return ve[15:0];
  endfunction

  function automatic logic trimmable(elem_type_e t, logic [LW-1:0] vc, logic [15:0] mc);
    if (t == ET_MATCH) begin
      return AW'(vc) < AW'(mc);
    end
    return 1'b1;
  endfunction

  function automatic logic [LW-1:0] len_inc(elem_type_e t, logic [LW-1:0] vc);
    logic [LW-1:0] r;
    case (t)
      ET_MATCH: r = vc;
      ET_MISM:  r = LW'(1);
      ET_DEL:   r = vc;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [LW-1:0] pos_inc(elem_type_e t, logic [LW-1:0] vc);
    logic [LW-1:0] r;
    case (t)
      ET_MATCH: r = vc;
      ET_MISM:  r = LW'(1);
      ET_DEL:   r = '0;
      default:  r = vc;
    endcase
    return r;
  endfunction

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [39:0]   pos_q, pos_d;
  logic [39:0]   ts_q, ts_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] rd_q, rd_d;
  logic          fend_q, fend_d;
  logic          lead_q, lead_d;
  logic          lany_q, lany_d;
  logic [LW-1:0] acc_q, acc_d;
  logic          mtp_q, mtp_d;
  logic [LW-1:0] mtv_q, mtv_d;
  logic          mtt_q, mtt_d;
  logic          gpa_q, gpa_d;
  logic          gpt_q, gpt_d;
  logic [LW-1:0] gdl_q, gdl_d;
  logic [LW-1:0] gil_q, gil_d;
  logic          gdd_q, gdd_d;
  logic          gid_q, gid_d;
  logic [CW-1:0] wc_q, wc_d;
  logic [IW-1:0] bk_q, bk_d;
  logic [CW-1:0] cut_q, cut_d;
  logic          tail_q, tail_d;
  logic [LW-1:0] acc2_q, acc2_d;
  logic [CW-1:0] ei_q, ei_d;
  logic          ov_q, ov_d;
  elem_t         oel_q, oel_d;
  logic          oem_q, oem_d;
  logic          olast_q, olast_d;

  logic          st_we, st_re, rs_we, rs_re;
  logic [IW-1:0] st_waddr, st_raddr, rs_waddr, rs_raddr;
  elem_t         st_wdata, rs_wdata;
  logic [EW-1:0] st_rbits, rs_rbits;
  elem_t         sr, rr;
  logic [LW-1:0] svc, rvc;
  logic          in_fire, want_d, want_i, tail_emit;
  logic [LW-1:0] base_dl, base_il;

  cnt_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rbits)
  );

  cnt_ram #(.WIDTH(EW), .DEPTH(MAX_ELEMENTS)) u_result (
    .clk_i   (clk_i),
    .we_i    (rs_we),
    .waddr_i (rs_waddr),
    .wdata_i (rs_wdata),
    .re_i    (rs_re),
    .raddr_i (rs_raddr),
    .rdata_o (rs_rbits)
  );

  assign sr        = elem_t'(st_rbits);
  assign rr        = elem_t'(rs_rbits);
  assign svc       = clamp_len(sr.value);
  assign rvc       = clamp_len(rr.value);
  assign in_ready_o = (state_q == S_LOAD);
  assign in_fire   = in_valid_i & in_ready_o;
  assign want_d    = (gdl_q != '0) && !gdd_q;
  assign want_i    = (gil_q != '0) && !gid_q;
  assign tail_emit = tail_q && (acc2_q != '0);
  assign base_dl   = gpa_q ? gdl_q : '0;
  assign base_il   = gpa_q ? gil_q : '0;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    ts_d    = ts_q;
    ovf_d   = ovf_q;
    rd_d    = rd_q;
    fend_d  = fend_q;
    lead_d  = lead_q;
    lany_d  = lany_q;
    acc_d   = acc_q;
    mtp_d   = mtp_q;
    mtv_d   = mtv_q;
    mtt_d   = mtt_q;
    gpa_d   = gpa_q;
    gpt_d   = gpt_q;
    gdl_d   = gdl_q;
    gil_d   = gil_q;
    gdd_d   = gdd_q;
    gid_d   = gid_q;
    wc_d    = wc_q;
    bk_d    = bk_q;
    cut_d   = cut_q;
    tail_d  = tail_q;
    acc2_d  = acc2_q;
    ei_d    = ei_q;
    ov_d    = ov_q;
    oel_d   = oel_q;
    oem_d   = oem_q;
    olast_d = olast_q;

    st_we    = 1'b0;
    st_waddr = cnt_q[IW-1:0];
    st_wdata.etype = elem_type_e'(element_type_i);
    st_wdata.trim  = element_trim_i;
    st_wdata.value = element_value_i;
    st_re    = 1'b0;
    st_raddr = rd_q[IW-1:0];
    rs_we    = 1'b0;
    rs_waddr = wc_q[IW-1:0];
    rs_wdata = '0;
    rs_re    = 1'b0;
    rs_raddr = bk_q;

    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          if (cnt_q == '0) begin
            pos_d = start_position_i;
            ts_d  = text_start_i;
          end
          if (cnt_q < CW'(MAX_ELEMENTS)) begin
            st_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (is_last_i) begin
            state_d = S_FRD;
            rd_d    = '0;
            lead_d  = 1'b1;
            lany_d  = 1'b0;
            acc_d   = '0;
            mtp_d   = 1'b0;
            gpa_d   = 1'b0;
            wc_d    = '0;
          end
        end
      end
      S_FRD: begin
        fend_d  = (rd_q == cnt_q);
        st_re   = (rd_q != cnt_q);
        state_d = S_FPROC;
      end
      S_FPROC: begin
        if (lead_q) begin
          if (!fend_q && trimmable(sr.etype, svc, cfg_i.min_ctx)) begin
            acc_d   = sat_add(acc_q, len_inc(sr.etype, svc));
            pos_d   = pos_q + 40'(pos_inc(sr.etype, svc));
            lany_d  = 1'b1;
            rd_d    = rd_q + CW'(1);
            state_d = S_FRD;
          end else begin
            lead_d = 1'b0;
            if (lany_q) begin
              gpa_d = 1'b1;
              gpt_d = 1'b1;
              gdl_d = acc_q;
              gil_d = '0;
              gdd_d = 1'b0;
              gid_d = 1'b0;
            end
          end
        end else if (mtp_q && (fend_q || sr.etype != ET_MATCH)) begin
          rs_we          = 1'b1;
          rs_wdata.etype = ET_MATCH;
          rs_wdata.trim  = mtt_q;
          rs_wdata.value = sat16(mtv_q);
          wc_d           = wc_q + CW'(1);
          mtp_d          = 1'b0;
        end else if (gpa_q && (fend_q || sr.etype == ET_MATCH || sr.etype == ET_MISM)) begin
          if (want_d && (cfg_i.gap_del_first || !want_i)) begin
            rs_we          = 1'b1;
            rs_wdata.etype = ET_DEL;
            rs_wdata.trim  = gpt_q;
            rs_wdata.value = sat16(gdl_q);
            wc_d           = wc_q + CW'(1);
            gdd_d          = 1'b1;
          end else if (want_i) begin
            rs_we          = 1'b1;
            rs_wdata.etype = ET_INS;
            rs_wdata.trim  = 1'b0;
            rs_wdata.value = sat16(gil_q);
            wc_d           = wc_q + CW'(1);
            gid_d          = 1'b1;
          end else begin
            gpa_d = 1'b0;
          end
        end else if (fend_q) begin
          cut_d  = wc_q;
          tail_d = 1'b0;
          acc2_d = '0;
          ei_d   = '0;
          bk_d   = IW'(wc_q - CW'(1));
          if (wc_q == '0) begin
            state_d = S_EST;
          end else begin
            state_d = S_BRD;
          end
        end else begin
          case (sr.etype)
            ET_MISM: begin
              rs_we    = 1'b1;
              rs_wdata = sr;
              wc_d     = wc_q + CW'(1);
            end
            ET_MATCH: begin
              mtp_d = 1'b1;
              mtv_d = mtp_q ? sat_add(mtv_q, svc) : svc;
              mtt_d = sr.trim;
            end
            default: begin
              gpa_d = 1'b1;
              if (!gpa_q) begin
                gpt_d = (sr.etype == ET_DEL) && sr.trim;
                gdd_d = 1'b0;
                gid_d = 1'b0;
              end
              if (sr.etype == ET_DEL) begin
                gdl_d = sat_add(base_dl, svc);
                gil_d = base_il;
              end else begin
                gdl_d = base_dl;
                gil_d = sat_add(base_il, svc);
              end
            end
          endcase
          rd_d    = rd_q + CW'(1);
          state_d = S_FRD;
        end
      end
      S_BRD: begin
        rs_re   = 1'b1;
        state_d = S_BPROC;
      end
      S_BPROC: begin
        if (trimmable(rr.etype, rvc, cfg_i.min_ctx)) begin
          acc2_d = sat_add(acc2_q, len_inc(rr.etype, rvc));
          cut_d  = CW'(bk_q);
          tail_d = 1'b1;
          if (bk_q == '0) begin
            state_d = S_EST;
          end else begin
            bk_d    = bk_q - IW'(1);
            state_d = S_BRD;
          end
        end else begin
          state_d = S_EST;
        end
      end
      S_EST: begin
        if (ei_q < cut_q) begin
          rs_re    = 1'b1;
          rs_raddr = ei_q[IW-1:0];
          state_d  = S_ECAP;
        end else if (tail_emit) begin
          oel_d.etype = ET_DEL;
          oel_d.trim  = 1'b1;
          oel_d.value = sat16(acc2_q);
          oem_d       = 1'b0;
          olast_d     = 1'b1;
          ov_d        = 1'b1;
          state_d     = S_EWAIT;
        end else begin
          oel_d   = '0;
          oem_d   = 1'b1;
          olast_d = 1'b1;
          ov_d    = 1'b1;
          state_d = S_EWAIT;
        end
      end
      S_ECAP: begin
        oel_d   = rr;
        oem_d   = 1'b0;
        olast_d = ((ei_q + CW'(1)) == cut_q) && !tail_emit;
        ov_d    = 1'b1;
        state_d = S_EWAIT;
      end
      S_EWAIT: begin
        if (out_ready_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            ei_d    = ei_q + CW'(1);
            state_d = S_EST;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      pos_q   <= '0;
      ts_q    <= '0;
      ovf_q   <= 1'b0;
      rd_q    <= '0;
      fend_q  <= 1'b0;
      lead_q  <= 1'b0;
      lany_q  <= 1'b0;
      acc_q   <= '0;
      mtp_q   <= 1'b0;
      mtv_q   <= '0;
      mtt_q   <= 1'b0;
      gpa_q   <= 1'b0;
      gpt_q   <= 1'b0;
      gdl_q   <= '0;
      gil_q   <= '0;
      gdd_q   <= 1'b0;
      gid_q   <= 1'b0;
      wc_q    <= '0;
      bk_q    <= '0;
      cut_q   <= '0;
      tail_q  <= 1'b0;
      acc2_q  <= '0;
      ei_q    <= '0;
      ov_q    <= 1'b0;
      oel_q   <= '0;
      oem_q   <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      ts_q    <= ts_d;
      ovf_q   <= ovf_d;
      rd_q    <= rd_d;
      fend_q  <= fend_d;
      lead_q  <= lead_d;
      lany_q  <= lany_d;
      acc_q   <= acc_d;
      mtp_q   <= mtp_d;
      mtv_q   <= mtv_d;
      mtt_q   <= mtt_d;
      gpa_q   <= gpa_d;
      gpt_q   <= gpt_d;
      gdl_q   <= gdl_d;
      gil_q   <= gil_d;
      gdd_q   <= gdd_d;
      gid_q   <= gid_d;
      wc_q    <= wc_d;
      bk_q    <= bk_d;
      cut_q   <= cut_d;
      tail_q  <= tail_d;
      acc2_q  <= acc2_d;
      ei_q    <= ei_d;
      ov_q    <= ov_d;
      oel_q   <= oel_d;
      oem_q   <= oem_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign out_elem_o   = oel_q;
  assign empty_o      = oem_q;
  assign last_o       = olast_q;
  assign overflow_o   = ovf_q;
  assign pos_o        = pos_q;
  assign text_start_o = ts_q;

endmodule

// ===== hw/rtl/cigar_normalize_trim.sv =====
// Top level of the CIGAR normalize and trim block.
// Elements are loaded into the element store; the forward pass then reads each stored
// element, flushes match runs, emits gap elements, closes each gap and leaves the leading
// trim. The end-trim walk reads back each result it examines. Each stored result is read
// back and registered before it is offered; a closing trim deletion or empty result is built
// directly, held until taken. Throughput: one CIGAR at a time, taken after the final transfer.
module cigar_normalize_trim #(
  parameter int MAX_ELEMENTS = 64,
  parameter int LENGTH_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  element_type_i,
  input  logic        element_trim_i,
  input  logic [15:0] element_value_i,
  input  logic [39:0] start_position_i,
  input  logic [39:0] text_start_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_type_o,
  output logic        out_trim_o,
  output logic [15:0] out_value_o,
  output logic [39:0] adjusted_position_o,
  output logic signed [40:0] text_offset_o,
  output logic        empty_result_o,
  output logic        overflow_o,
  output logic        last_out_o
);
  import cnt_pkg::*;

  cfg_t        cfg;
  elem_t       oel;
  logic [39:0] pos;
  logic [39:0] ts;

  cnt_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cnt_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_type_i   (element_type_i),
    .element_trim_i   (element_trim_i),
    .element_value_i  (element_value_i),
    .start_position_i (start_position_i),
    .text_start_i     (text_start_i),
    .is_last_i        (is_last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_elem_o       (oel),
    .empty_o          (empty_result_o),
    .last_o           (last_out_o),
    .overflow_o       (overflow_o),
    .pos_o            (pos),
    .text_start_o     (ts)
  );

  assign out_type_o          = oel.etype;
  assign out_trim_o          = oel.trim;
  assign out_value_o         = oel.value;
  assign adjusted_position_o = pos;
  assign text_offset_o       = $signed({1'b0, pos} - {1'b0, ts});

endmodule

// ===== bench/cigar_normalize_trim_tb.sv =====
// Self-checking testbench for the CIGAR normalize and trim block.
module cigar_normalize_trim_tb;
  import cnt_pkg::*;

  typedef struct {
    elem_type_e  etype;
    logic        trim;
    logic [15:0] value;
    logic [39:0] start_pos;
    logic [39:0] text_start;
    logic        last;
  } element_item_t;

  typedef struct {
    elem_type_e         etype;
    logic               trim;
    logic [15:0]        value;
    logic [39:0]        adj_pos;
    logic signed [40:0] toff;
    logic               empty;
    logic               ovf;
    logic               last;
  } norm_result_t;

  localparam int CAPACITY  = 64;
  localparam int LEN_LIMIT = 65535;
  localparam int STALL_MAX = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] element_type_i = '0;
  logic element_trim_i = 1'b0;
  logic [15:0] element_value_i = '0;
  logic [39:0] start_position_i = '0;
  logic [39:0] text_start_i = '0;
  logic is_last_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] out_type_o;
  logic out_trim_o;
  logic [15:0] out_value_o;
  logic [39:0] adjusted_position_o;
  logic signed [40:0] text_offset_o;
  logic empty_result_o, overflow_o, last_out_o;

  cigar_normalize_trim u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  element_item_t pending_elements[$];
  norm_result_t  expected_results[$];
  int  fail_count = 0;
  int  results_seen = 0;
  int  cigars_sent = 0;
  int  idle_pct = 30;
  bit  rx_hold = 1'b0;
  bit  stim_done = 1'b0;
  int  quiet_cycles = 0;

  // Predictor state.
  element_item_t cig_buf[$];
  logic [15:0] min_ctx = 16'd0;
  bit gap_del_first = 1'b1;

  function automatic int unsigned sat16(int unsigned a, int unsigned b);
    return (a + b > LEN_LIMIT) ? LEN_LIMIT : a + b;
  endfunction

  function automatic bit trim_step(elem_type_e t, int unsigned v, ref int unsigned acc,
                                   ref logic [39:0] pos);
    case (t)
      ET_MATCH: begin
        if (v >= min_ctx) return 1'b0;
        acc = sat16(acc, v);
        pos = pos + v;
      end
      ET_MISM: begin
        acc = sat16(acc, 1);
        pos = pos + 1;
      end
      ET_DEL: acc = sat16(acc, v);
      default: pos = pos + v;
    endcase
    return 1'b1;
  endfunction

  task automatic normalize_cigar();
    elem_type_e t[$], ot[$];
    logic a[$], oa[$];
    int unsigned v[$], ov[$];
    int unsigned acc, dl, il, n, i, m, lst;
    logic [39:0] pos, dummy;
    logic signed [40:0] toff;
    bit ovf, ht;
    norm_result_t r;
    ovf = cig_buf.size() > CAPACITY;
    n = ovf ? CAPACITY : cig_buf.size();
    for (int k = 0; k < n; k++) begin
      t.push_back(cig_buf[k].etype);
      a.push_back(cig_buf[k].trim);
      v.push_back(32'(cig_buf[k].value));
    end
    pos = cig_buf[0].start_pos;
    acc = 0;
    i = 0;
    for (int j = 0; j < n; j++) begin
      if (!trim_step(t[j], v[j], acc, pos)) break;
      t[j] = ET_DEL;
      a[j] = 1'b1;
      v[j] = acc;
      i = j;
    end
    while (i < n) begin
      if (t[i] == ET_MISM) begin
        ot.push_back(t[i]); oa.push_back(a[i]); ov.push_back(v[i]);
        i++;
      end else if (t[i] == ET_MATCH) begin
        if (i + 1 < n && t[i+1] == ET_MATCH) v[i+1] = sat16(v[i+1], v[i]);
        else begin
          ot.push_back(t[i]); oa.push_back(a[i]); ov.push_back(v[i]);
        end
        i++;
      end else begin
        dl = 0;
        il = 0;
        ht = (t[i] == ET_DEL) && a[i];
        while (i < n && (t[i] == ET_DEL || t[i] == ET_INS)) begin
          if (t[i] == ET_DEL) dl = sat16(dl, v[i]);
          else il = sat16(il, v[i]);
          i++;
        end
        if (gap_del_first && dl > 0) begin
          ot.push_back(ET_DEL); oa.push_back(ht); ov.push_back(dl);
        end
        if (il > 0) begin
          ot.push_back(ET_INS); oa.push_back(1'b0); ov.push_back(il);
        end
        if (!gap_del_first && dl > 0) begin
          ot.push_back(ET_DEL); oa.push_back(ht); ov.push_back(dl);
        end
      end
    end
    m = ot.size();
    if (m > 0) begin
      lst = m - 1;
      acc = 0;
      dummy = '0;
      if (trim_step(ot[lst], ov[lst], acc, dummy)) begin
        while (lst > 0) begin
          lst--;
          if (!trim_step(ot[lst], ov[lst], acc, dummy)) break;
          m--;
        end
        ot[m-1] = ET_DEL;
        oa[m-1] = 1'b1;
        ov[m-1] = acc;
        if (acc == 0) m--;
      end
    end
    toff = $signed({1'b0, pos}) - $signed({1'b0, cig_buf[0].text_start});
    r.adj_pos = pos;
    r.toff = toff;
    r.ovf = ovf;
    if (m == 0) begin
      r.etype = ET_MATCH; r.trim = 1'b0; r.value = '0; r.empty = 1'b1; r.last = 1'b1;
      expected_results.push_back(r);
    end else begin
      for (int k = 0; k < m; k++) begin
        r.etype = ot[k]; r.trim = oa[k]; r.value = ov[k][15:0];
        r.empty = 1'b0; r.last = (k + 1 == m);
        expected_results.push_back(r);
      end
    end
    cig_buf.delete();
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %0h, expected %0h", what, $time, got, want);
    fail_count++;
  endtask

  // Driver.
  always @(posedge clk_i) begin
    element_item_t it;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        cig_buf.push_back(pending_elements.pop_front());
        if (is_last_i) begin
          normalize_cigar();
          cigars_sent++;
        end
      end
      if ((!in_valid_i || in_ready_o) && pending_elements.size() > 0 &&
          !($urandom_range(99) < idle_pct)) begin
        it = pending_elements[0];
        in_valid_i <= 1'b1;
        element_type_i <= it.etype;
        element_trim_i <= it.trim;
        element_value_i <= it.value;
        start_position_i <= it.start_pos;
        text_start_i <= it.text_start;
        is_last_i <= it.last;
      end else if (in_valid_i && in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk_i) begin
    norm_result_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_value_o, 0);
        end else begin
          e = expected_results.pop_front();
          if (empty_result_o !== e.empty) report_mismatch("empty_result", empty_result_o, e.empty);
          if (!e.empty) begin
            if (out_type_o !== e.etype) report_mismatch("out_type", out_type_o, e.etype);
            if (out_trim_o !== e.trim) report_mismatch("out_trim", out_trim_o, e.trim);
            if (out_value_o !== e.value) report_mismatch("out_value", out_value_o, e.value);
          end
          if (adjusted_position_o !== e.adj_pos)
            report_mismatch("adjusted_position", adjusted_position_o, e.adj_pos);
          if (text_offset_o !== e.toff) report_mismatch("text_offset", text_offset_o, e.toff);
          if (overflow_o !== e.ovf) report_mismatch("overflow", overflow_o, e.ovf);
          if (last_out_o !== e.last) report_mismatch("last_out", last_out_o, e.last);
        end
      end
      out_ready_i <= !rx_hold && !($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (quiet_cycles > STALL_MAX) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic element_item_t make_elem(elem_type_e t, logic tr, logic [15:0] v,
                                              logic lst);
    element_item_t it;
    it.etype = t;
    it.trim = tr;
    it.value = v;
    it.start_pos = 40'({$urandom, $urandom});
    it.text_start = 40'({$urandom, $urandom});
    it.last = lst;
    return it;
  endfunction

  task automatic queue_cigar(int len, bit wellformed);
    elem_type_e t;
    logic [15:0] v;
    for (int k = 0; k < len; k++) begin
      t = elem_type_e'($urandom_range(3));
      if (wellformed && k > 0 && k < len - 1 && $urandom_range(1)) t = ET_MATCH;
      case ($urandom_range(4))
        0: v = 16'd0;
        1: v = 16'hFFFF;
        2: v = 16'($urandom);
        default: v = 16'($urandom_range(40));
      endcase
      pending_elements.push_back(make_elem(t, 1'($urandom_range(1)), v, k == len - 1));
    end
  endtask

  task automatic wait_drained();
    while (pending_elements.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] ctx, bit gap_first);
    apb_write(3'(4 * REG_MIN_CTX), {16'd0, ctx});
    apb_write(3'(4 * REG_GAP_ORDER), {31'd0, gap_first});
    min_ctx = ctx;
    gap_del_first = gap_first;
  endtask

  initial begin
    int budget;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_config(16'd5, 1'b1);

    // Directed CIGARs: trims at both ends, gaps, saturation, empty and overflow.
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'd3, 1'b0));
    pending_elements.push_back(make_elem(ET_MISM, 1'b1, 16'd2, 1'b0));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'hFFFF, 1'b0));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b1, 16'hFFFF, 1'b0));
    pending_elements.push_back(make_elem(ET_INS, 1'b1, 16'd7, 1'b0));
    pending_elements.push_back(make_elem(ET_DEL, 1'b0, 16'd9, 1'b0));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'd20, 1'b0));
    pending_elements.push_back(make_elem(ET_DEL, 1'b1, 16'hFFFF, 1'b0));
    pending_elements.push_back(make_elem(ET_DEL, 1'b1, 16'hFFFF, 1'b0));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'd30, 1'b0));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'd2, 1'b0));
    pending_elements.push_back(make_elem(ET_INS, 1'b0, 16'd4, 1'b1));
    pending_elements.push_back(make_elem(ET_DEL, 1'b0, 16'd0, 1'b1));
    pending_elements.push_back(make_elem(ET_MATCH, 1'b0, 16'd100, 1'b0));
    pending_elements.push_back(make_elem(ET_DEL, 1'b0, 16'd0, 1'b0));
    pending_elements.push_back(make_elem(ET_INS, 1'b0, 16'd0, 1'b1));
    pending_elements.push_back(make_elem(ET_INS, 1'b0, 16'hFFFF, 1'b1));
    wait_drained();
    queue_cigar(70, 1'b1);
    wait_drained();

    // Receiver holds off while the sender keeps offering elements.
    rx_hold = 1'b1;
    queue_cigar(3, 1'b1);
    queue_cigar(4, 1'b1);
    queue_cigar(5, 1'b1);
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
    wait_drained();

    budget = 230;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(16'd0, 1'b0);
        1: set_config(16'hFFFF, 1'b1);
        2: set_config(16'($urandom_range(60)), 1'b0);
        default: set_config(16'($urandom_range(60)), 1'b1);
      endcase
      idle_pct = (phase == 2) ? 0 : 30;
      for (int left = budget / 4; left > 0; ) begin
        int len;
        len = $urandom_range(1, 10);
        queue_cigar(len, $urandom_range(9) != 0);
        left -= len;
      end
      wait_drained();
    end
    stim_done = 1'b1;
    $display("Sent %0d CIGARs and checked %0d results over five register settings.",
             cigars_sent, results_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/cnt_pkg.sv
hw/rtl/cnt_ram.sv
hw/rtl/cnt_apb.sv
hw/rtl/cnt_ctrl.sv
hw/rtl/cigar_normalize_trim.sv
bench/cigar_normalize_trim_tb.sv
